@@ design/wsts_pkg.sv @@
// Shared types and constants of the work-stealing task scheduler.
// Used by wsts_store and work_stealing_task_scheduler; depends on nothing.
package wsts_pkg;

  localparam int DEF_MAX_WORKERS   = 8;
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_TASK_ID_WIDTH = 16;
  localparam logic [3:0] CFG_WORKERS_RESET = 4'd8;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_SUBMIT    = 2'd0,
    OP_SUBMIT_TO = 2'd1,
    OP_FETCH     = 2'd2,
    OP_DONE      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    op_e         operation;
    logic [2:0]  worker_index;
    logic [15:0] task_id;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] granted_task;
    logic [2:0]  source_worker;
    logic        was_stolen;
    logic [7:0]  outstanding_tasks;
    logic        all_done;
  } rsp_t;

endpackage

@@ design/wsts_store.sv @@
// Task identifier storage for all worker deques: one write and one read port.
// Read data is registered. Depends on wsts_pkg for default sizes.
module wsts_store #(
  parameter int DEPTH = wsts_pkg::DEF_MAX_WORKERS * wsts_pkg::DEF_QUEUE_DEPTH,
  parameter int WIDTH = wsts_pkg::DEF_TASK_ID_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/work_stealing_task_scheduler.sv @@
// Work-stealing task scheduler top level: sequencer, deque pointers and counters.
// Depends on wsts_pkg and wsts_store.
//
// Usage: present a request on req_i with start_i high; the transaction is taken
// at a rising edge where busy_o is low. busy_o stays high while the sequencer
// works. The response appears on rsp_o with done_o high for exactly one cycle;
// the receiver cannot stall it, and a new start may be taken in that cycle.
// cfg_we_i writes the active worker count from cfg_wdata_i; write it only idle.
// Steps from accept to done_o:
//   task done or index out of range: answered from idle, no sequencer state
//   submit to worker: push state
//   round-robin submit: modulo state, subtracting the worker count from the pointer
//     until it is below that count (none when unchanged), then push state
//   fetch from own deque: pop, read wait (read port has a registered output)
//   fetch by steal: pop, then scan from worker 0 to the victim, then read wait,
//     one fill count examined per cycle; a failed scan ends after the last worker
// Reset clears all deque pointers, fill counts, the round-robin pointer and
// the outstanding count; storage needs no clearing, since only written entries
// are read. The worker count returns to 8.
module work_stealing_task_scheduler #(
  parameter int MAX_WORKERS   = wsts_pkg::DEF_MAX_WORKERS,
  parameter int QUEUE_DEPTH   = wsts_pkg::DEF_QUEUE_DEPTH,
  parameter int TASK_ID_WIDTH = wsts_pkg::DEF_TASK_ID_WIDTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  wsts_pkg::req_t  req_i,
  output logic            done_o,
  output wsts_pkg::rsp_t  rsp_o,
  input  logic            cfg_we_i,
  input  logic [3:0]      cfg_wdata_i
);

  localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW = WW + 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = QW + 1;
  localparam int SW = QW + 2;
  localparam int DEPTH = MAX_WORKERS * QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RRMOD,
    S_PUSH,
    S_POP,
    S_SCAN,
    S_RDWAIT
  } state_e;

  state_e              state_q;
  logic [3:0]          cfg_q;
  logic [CW-1:0]       wi_q;
  logic [15:0]         task_q;
  logic [CW-1:0]       cur_q;
  logic [WW-1:0]       rr_q;
  logic [7:0]          count_q;
  logic [QW-1:0]       head_q [MAX_WORKERS];
  logic [FW-1:0]       fill_q [MAX_WORKERS];
  logic                done_q;
  wsts_pkg::rsp_t      rsp_q;
  logic                stolen_q;

  logic [CW-1:0]       wc;
  logic [WW-1:0]       cur_idx;
  logic [QW-1:0]       head_cur;
  logic [FW-1:0]       fill_cur;
  logic [SW-1:0]       sum_push;
  logic [SW-1:0]       sum_pop;
  logic [QW-1:0]       slot_push;
  logic [QW-1:0]       slot_pop;
  logic [QW-1:0]       head_next;
  logic [AW-1:0]       base_addr;
  logic                full_cur;
  logic                empty_cur;
  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic [TASK_ID_WIDTH-1:0] mem_rdata;
  logic [CW-1:0]       cur_inc;
  logic [7:0]          count_inc;

  always_comb begin
    if (cfg_q == 4'd0) begin
      wc = CW'(1);
    end else if (32'(cfg_q) > MAX_WORKERS) begin
      wc = CW'(MAX_WORKERS);
    end else begin
      wc = CW'(cfg_q);
    end
  end

  assign cur_idx   = cur_q[WW-1:0];
  assign head_cur  = head_q[cur_idx];
  assign fill_cur  = fill_q[cur_idx];
  assign full_cur  = (fill_cur == FW'(QUEUE_DEPTH));
  assign empty_cur = (fill_cur == '0);
  assign sum_push  = SW'(head_cur) + SW'(fill_cur);
  assign sum_pop   = sum_push - SW'(1);
  assign slot_push = (sum_push >= SW'(QUEUE_DEPTH)) ? QW'(sum_push - SW'(QUEUE_DEPTH))
                                                    : QW'(sum_push);
  assign slot_pop  = (sum_pop >= SW'(QUEUE_DEPTH)) ? QW'(sum_pop - SW'(QUEUE_DEPTH))
                                                   : QW'(sum_pop);
  assign head_next = (32'(head_cur) + 1 >= QUEUE_DEPTH) ? '0 : QW'(32'(head_cur) + 1);
  assign base_addr = AW'(32'(cur_idx) * QUEUE_DEPTH);
  assign cur_inc   = cur_q + CW'(1);
  assign count_inc = (count_q == wsts_pkg::COUNT_MAX) ? count_q : count_q + 8'd1;

  always_comb begin
    mem_we    = (state_q == S_PUSH) && !full_cur;
    mem_waddr = base_addr + AW'(slot_push);
    mem_re    = 1'b0;
    mem_raddr = base_addr + AW'(slot_pop);
    if (state_q == S_POP) begin
      mem_re = !empty_cur;
    end else if (state_q == S_SCAN) begin
      mem_re    = (cur_q < wc) && (cur_q != wi_q) && !empty_cur;
      mem_raddr = base_addr + AW'(head_cur);
    end
  end

  wsts_store #(
    .DEPTH (DEPTH),
    .WIDTH (TASK_ID_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (TASK_ID_WIDTH'(task_q)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cfg_q    <= wsts_pkg::CFG_WORKERS_RESET;
      rr_q     <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      stolen_q <= 1'b0;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            wi_q     <= CW'(req_i.worker_index);
            task_q   <= req_i.task_id;
            stolen_q <= 1'b0;
            rsp_q.granted_task  <= '0;
            rsp_q.source_worker <= '0;
            rsp_q.was_stolen    <= 1'b0;
            rsp_q.status        <= wsts_pkg::ST_OK;
            unique case (req_i.operation)
              wsts_pkg::OP_SUBMIT: begin
                cur_q   <= CW'(rr_q);
                state_q <= S_RRMOD;
              end
              wsts_pkg::OP_SUBMIT_TO, wsts_pkg::OP_FETCH: begin
                if (32'(req_i.worker_index) >= 32'(wc)) begin
                  rsp_q.status            <= wsts_pkg::ST_RANGE;
                  rsp_q.outstanding_tasks <= count_q;
                  rsp_q.all_done          <= (count_q == '0);
                  done_q                  <= 1'b1;
                end else begin
                  cur_q   <= CW'(req_i.worker_index);
                  state_q <= (req_i.operation == wsts_pkg::OP_FETCH) ? S_POP : S_PUSH;
                end
              end
              wsts_pkg::OP_DONE: begin
                if (count_q == '0) begin
                  rsp_q.status            <= wsts_pkg::ST_EMPTY;
                  rsp_q.outstanding_tasks <= '0;
                  rsp_q.all_done          <= 1'b1;
                end else begin
                  count_q                 <= count_q - 8'd1;
                  rsp_q.outstanding_tasks <= count_q - 8'd1;
                  rsp_q.all_done          <= (count_q == 8'd1);
                end
                done_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_RRMOD: begin
          if (cur_q >= wc) begin
            cur_q <= cur_q - wc;
          end else begin
            rr_q    <= (cur_inc == wc) ? '0 : WW'(cur_inc);
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          rsp_q.source_worker <= 3'(cur_q);
          if (full_cur) begin
            rsp_q.status            <= wsts_pkg::ST_FULL;
            rsp_q.outstanding_tasks <= count_q;
            rsp_q.all_done          <= (count_q == '0);
          end else begin
            fill_q[cur_idx]         <= fill_cur + FW'(1);
            count_q                 <= count_inc;
            rsp_q.status            <= wsts_pkg::ST_OK;
            rsp_q.outstanding_tasks <= count_inc;
            rsp_q.all_done          <= 1'b0;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_POP: begin
          rsp_q.outstanding_tasks <= count_q;
          rsp_q.all_done          <= (count_q == '0);
          if (!empty_cur) begin
            fill_q[cur_idx]     <= fill_cur - FW'(1);
            rsp_q.source_worker <= 3'(cur_q);
            state_q             <= S_RDWAIT;
          end else begin
            cur_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur_q >= wc) begin
            rsp_q.status <= wsts_pkg::ST_EMPTY;
            done_q       <= 1'b1;
            state_q      <= S_IDLE;
          end else if ((cur_q != wi_q) && !empty_cur) begin
            head_q[cur_idx]     <= head_next;
            fill_q[cur_idx]     <= fill_cur - FW'(1);
            rsp_q.source_worker <= 3'(cur_q);
            stolen_q            <= 1'b1;
            state_q             <= S_RDWAIT;
          end else begin
            cur_q <= cur_inc;
          end
        end
        S_RDWAIT: begin
          rsp_q.granted_task <= 16'(mem_rdata);
          rsp_q.was_stolen   <= stolen_q;
          rsp_q.status       <= wsts_pkg::ST_OK;
          done_q             <= 1'b1;
          state_q            <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
